[src/assert_macros.svh]
// Assertion macros shared by the RTL. Each use expands to one labeled
// concurrent assertion that is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/swrc_pkg.sv]
package swrc_pkg;

  // The window length is a power of two, so the average is a right shift by POS_W.
  localparam int WINDOW_SECONDS = 16;
  localparam int POS_W          = $clog2(WINDOW_SECONDS);
  localparam int CNT_W          = $clog2(WINDOW_SECONDS + 1);
  // The exact bucket sum stays below WINDOW_SECONDS * 2^32.
  localparam int SUM_W          = 32 + POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic             wr_en;
    logic [POS_W-1:0] addr;
    logic [31:0]      wdata;
  } ring_cmd_t;

endpackage

[src/swrc_in_if.sv]
interface swrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_seconds;
  logic [15:0] increment;

  modport source (output valid, output now_seconds, output increment, input ready);
  modport sink (input valid, input now_seconds, input increment, output ready);
endinterface

[src/swrc_out_if.sv]
interface swrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_average;
  logic [31:0] running_total;
  logic [31:0] current_count;

  modport source (output valid, output window_average, output running_total,
                  output current_count, input ready);
  modport sink (input valid, input window_average, input running_total,
                input current_count, output ready);
endinterface

[src/swrc_ring.sv]
module swrc_ring import swrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ring_cmd_t   cmd,
  output logic [31:0] rd_data
);

  logic [31:0]               mem [WINDOW_SECONDS];
  logic [WINDOW_SECONDS-1:0] vld_r;
  logic [31:0]               rd_raw_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rd_raw_r <= mem[cmd.addr];
      rd_vld_r <= vld_r[cmd.addr];
    end
  end

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[cmd.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

[src/swrc_div.sv]
module swrc_div import swrc_pkg::*; (
  input  logic             clk,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic [31:0]      quotient
);

  logic [31:0] q_r;

  // Dividing by the window is a shift; the sum bound keeps the quotient in 32 bits.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend[SUM_W-1:POS_W];
    end
  end

  assign quotient = q_r;

endmodule

[src/sliding_window_rate_counter.sv]
// An input transfer passes k ring steps (ST_WR_RD, ST_WR_UPD), then ST_DIV_GO and
// ST_DIV_WAIT, before a valid result; k is the number of seconds the ring advances
// (0 when time stands still, goes back or jumps past the window). Each advanced
// second costs a bucket read and a bucket write; the average is the bucket sum
// shifted right by log2 of the window. One event is in flight at a time, and a
// result not yet taken holds the next event. Reset clears counters and buckets.
module sliding_window_rate_counter import swrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  swrc_in_if.sink     in_chan,
  swrc_out_if.source  out_chan
);

`include "assert_macros.svh"

  state_t           state_r, state_nxt;
  logic [31:0]      count_r, count_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [31:0]      last_val_r, last_val_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      avg_r, tot_out_r, cnt_out_r;

  logic [31:0]      diff;
  logic             big;
  logic             adv;
  logic             accept;
  logic [31:0]      inc32;
  logic [31:0]      wval;
  logic             out_load;
  logic             div_start;
  logic [31:0]      div_quot;
  logic [31:0]      ring_rd;
  ring_cmd_t        cmd;

  swrc_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (ring_rd)
  );

  swrc_div u_div (
    .clk      (clk),
    .start    (div_start),
    .dividend (sum_r),
    .quotient (div_quot)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign diff          = in_chan.now_seconds - prev_r;
  assign big           = $signed(diff) > $signed(32'(WINDOW_SECONDS));
  assign adv           = !diff[31] && (diff != '0) && !big;
  assign inc32         = 32'(in_chan.increment);
  // Skipped seconds get zero buckets; the last write of the run stores the count.
  assign wval          = (rem_r == CNT_W'(1)) ? last_val_r : '0;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    prev_nxt     = prev_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    rem_nxt      = rem_r;
    last_val_nxt = last_val_r;
    cmd          = '0;
    cmd.addr     = pos_r;
    cmd.wdata    = wval;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prev_nxt = in_chan.now_seconds;
          if (big) begin
            cmd.clear = 1'b1;
            count_nxt = inc32;
            total_nxt = inc32;
            sum_nxt   = '0;
            state_nxt = ST_DIV_GO;
          end else if (adv) begin
            last_val_nxt = count_r;
            count_nxt    = inc32;
            total_nxt    = total_r + inc32;
            rem_nxt      = diff[CNT_W-1:0];
            state_nxt    = ST_WR_RD;
          end else begin
            count_nxt = count_r + inc32;
            total_nxt = total_r + inc32;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_WR_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WR_UPD;
      end
      ST_WR_UPD: begin
        cmd.wr_en = 1'b1;
        sum_nxt   = sum_r - SUM_W'(ring_rd) + SUM_W'(wval);
        pos_nxt   = (pos_r == POS_W'(WINDOW_SECONDS - 1)) ? '0 : pos_r + 1'b1;
        rem_nxt   = rem_r - 1'b1;
        state_nxt = (rem_r == CNT_W'(1)) ? ST_DIV_GO : ST_WR_RD;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    last_val_r <= last_val_nxt;
    if (out_load) begin
      avg_r     <= div_quot;
      tot_out_r <= total_r;
      cnt_out_r <= count_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.window_average = avg_r;
  assign out_chan.running_total  = tot_out_r;
  assign out_chan.current_count  = cnt_out_r;

  `ASSERT_NEXT(a_rd_then_upd, clk, rst_n, state_r == ST_WR_RD, state_r == ST_WR_UPD)
  `ASSERT_IMPLIES(a_rem_live, clk, rst_n, state_r == ST_WR_RD || state_r == ST_WR_UPD, rem_r != '0)
  `ASSERT_NEXT(a_pos_moves, clk, rst_n, state_r == ST_WR_UPD, pos_r != $past(pos_r))

endmodule
